// ===== rtl/core/nfhm_pkg.sv =====
// Shared constants, types and codes for the neuron fire history match unit.
`timescale 1ns / 1ps

package nfhm_pkg;

  localparam int HIST_LEN    = 512;
  localparam int PAT_LEN     = 6;
  localparam int CHUNK_BITS  = 64;
  localparam int MIN_ONES    = 3;
  localparam int NUM_CHUNKS  = (HIST_LEN + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int CHUNK_IDX_W = 3;
  localparam int CHUNK_SH    = $clog2(CHUNK_BITS);
  localparam int OFF_W       = $clog2(HIST_LEN);
  localparam int ONES_W      = $clog2(PAT_LEN + 1);

  localparam int SUM_W   = 8;
  localparam int DRAW_W  = 16;
  localparam int NOISE_W = 17;
  localparam int CNT_W   = 16;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_THRESH = 2'd0,
    REG_NOISE  = 2'd1,
    REG_ENABLE = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [SUM_W-1:0]   thresh;
    logic [NOISE_W-1:0] noise;
    logic               enable;
  } cfg_t;

  typedef struct packed {
    logic                   load_tick;
    logic                   load_chunk;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic                   last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/nfhm_in_if.sv =====
// Input channel interface: one tick of summed input and random draw per beat.
`timescale 1ns / 1ps

interface nfhm_in_if;
  logic                       valid;
  logic                       ready;
  logic [nfhm_pkg::SUM_W-1:0]  input_sum;
  logic [nfhm_pkg::DRAW_W-1:0] random_draw;

  modport source (output valid, output input_sum, output random_draw, input ready);
  modport sink   (input valid, input input_sum, input random_draw, output ready);
endinterface

// ===== rtl/core/nfhm_out_if.sv =====
// Result channel interface: one bitmap chunk with the tick's fire report per beat.
`timescale 1ns / 1ps

interface nfhm_out_if;
  logic                            valid;
  logic                            ready;
  logic                            fired;
  logic [nfhm_pkg::SUM_W-1:0]       fire_value;
  logic [nfhm_pkg::CNT_W-1:0]       steps_since_visit;
  logic [nfhm_pkg::CHUNK_IDX_W-1:0] chunk_index;
  logic [nfhm_pkg::CHUNK_BITS-1:0]  match_bits;
  logic                            last_in_run;

  modport source (output valid, output fired, output fire_value, output steps_since_visit,
                  output chunk_index, output match_bits, output last_in_run, input ready);
  modport sink   (input valid, input fired, input fire_value, input steps_since_visit,
                  input chunk_index, input match_bits, input last_in_run, output ready);
endinterface

// ===== rtl/core/nfhm_cfg.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module nfhm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nfhm_pkg::ADDR_W-1:0] paddr,
  input  logic [nfhm_pkg::DATA_W-1:0] pwdata,
  output logic [nfhm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output nfhm_pkg::cfg_t              cfg
);

  nfhm_pkg::cfg_t     cfg_r;
  nfhm_pkg::cfg_t     cfg_nxt;
  nfhm_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = nfhm_pkg::reg_idx_t'(paddr[nfhm_pkg::ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        nfhm_pkg::REG_THRESH: cfg_nxt.thresh = pwdata[nfhm_pkg::SUM_W-1:0];
        nfhm_pkg::REG_NOISE:  cfg_nxt.noise  = pwdata[nfhm_pkg::NOISE_W-1:0];
        nfhm_pkg::REG_ENABLE: cfg_nxt.enable = pwdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      nfhm_pkg::REG_THRESH: prdata = nfhm_pkg::DATA_W'(cfg_r.thresh);
      nfhm_pkg::REG_NOISE:  prdata = nfhm_pkg::DATA_W'(cfg_r.noise);
      nfhm_pkg::REG_ENABLE: prdata = nfhm_pkg::DATA_W'(cfg_r.enable);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh <= nfhm_pkg::SUM_W'(1);
      cfg_r.noise  <= '0;
      cfg_r.enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/nfhm_ctrl.sv =====
// Controller: takes one tick, then steps the chunk scan into the output register.
`timescale 1ns / 1ps

module nfhm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nfhm_pkg::dp_stat_t  stat,
  output nfhm_pkg::dp_cmd_t   cmd
);

  nfhm_pkg::state_t                 state_r;
  nfhm_pkg::state_t                 state_nxt;
  logic [nfhm_pkg::CHUNK_IDX_W-1:0] chunk_r;
  logic [nfhm_pkg::CHUNK_IDX_W-1:0] chunk_nxt;
  logic                             last_chunk;

  assign last_chunk = (chunk_r == nfhm_pkg::CHUNK_IDX_W'(nfhm_pkg::NUM_CHUNKS - 1));

  // Next state and chunk counter.
  always_comb begin
    state_nxt = state_r;
    chunk_nxt = chunk_r;
    unique case (state_r)
      nfhm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = nfhm_pkg::ST_SCAN;
          chunk_nxt = '0;
        end
      end
      nfhm_pkg::ST_SCAN: begin
        if (stat.out_free) begin
          chunk_nxt = chunk_r + 1'b1;
          if (last_chunk) begin
            state_nxt = nfhm_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = nfhm_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the channel and the datapath.
  always_comb begin
    in_ready       = 1'b0;
    cmd.load_tick  = 1'b0;
    cmd.load_chunk = 1'b0;
    cmd.chunk      = chunk_r;
    cmd.last       = last_chunk;
    unique case (state_r)
      nfhm_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_tick = in_valid;
      end
      nfhm_pkg::ST_SCAN: begin
        cmd.load_chunk = stat.out_free;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nfhm_pkg::ST_IDLE;
      chunk_r <= '0;
    end else begin
      state_r <= state_nxt;
      chunk_r <= chunk_nxt;
    end
  end

endmodule

// ===== rtl/core/nfhm_dp.sv =====
// Datapath: fire decision, idle counter, rotating history, window comparators, output register.
`timescale 1ns / 1ps

module nfhm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nfhm_pkg::cfg_t                cfg,
  input  nfhm_pkg::dp_cmd_t             cmd,
  output nfhm_pkg::dp_stat_t            stat,
  input  logic [nfhm_pkg::SUM_W-1:0]    input_sum,
  input  logic [nfhm_pkg::DRAW_W-1:0]   random_draw,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_fired,
  output logic [nfhm_pkg::SUM_W-1:0]    out_fire_value,
  output logic [nfhm_pkg::CNT_W-1:0]    out_steps_since_visit,
  output logic [nfhm_pkg::CHUNK_IDX_W-1:0] out_chunk_index,
  output logic [nfhm_pkg::CHUNK_BITS-1:0]  out_match_bits,
  output logic                          out_last_in_run
);

  // History bit 0 is the newest tick.
  logic [nfhm_pkg::HIST_LEN-1:0]   hist_r;
  logic [nfhm_pkg::HIST_LEN-1:0]   hist_nxt;
  logic [nfhm_pkg::CNT_W-1:0]      cnt_r;
  logic [nfhm_pkg::CNT_W-1:0]      cnt_nxt;
  logic [nfhm_pkg::CNT_W-1:0]      cnt_inc;
  logic [nfhm_pkg::PAT_LEN-1:0]    pat_r;
  logic [nfhm_pkg::PAT_LEN-1:0]    pat_new;
  logic                            scan_r;
  logic                            fired_r;
  logic [nfhm_pkg::SUM_W-1:0]      value_r;
  logic [nfhm_pkg::CNT_W-1:0]      steps_r;
  logic                            gate;
  logic                            fire;
  logic [nfhm_pkg::ONES_W-1:0]     ones;
  logic [nfhm_pkg::CHUNK_BITS-1:0] match;
  logic [nfhm_pkg::OFF_W-1:0]      chunk_base;

  logic                               ov_r;
  logic                               o_fired_r;
  logic [nfhm_pkg::SUM_W-1:0]         o_value_r;
  logic [nfhm_pkg::CNT_W-1:0]         o_steps_r;
  logic [nfhm_pkg::CHUNK_IDX_W-1:0]   o_chunk_r;
  logic [nfhm_pkg::CHUNK_BITS-1:0]    o_bits_r;
  logic                               o_last_r;

  // Noise at full scale or beyond always suppresses; zero never does.
  always_comb begin
    priority if (cfg.noise == '0) begin
      gate = 1'b1;
    end else if (cfg.noise[nfhm_pkg::NOISE_W-1]) begin
      gate = 1'b0;
    end else begin
      gate = random_draw > cfg.noise[nfhm_pkg::DRAW_W-1:0];
    end
  end

  assign fire    = cfg.enable && (input_sum >= cfg.thresh) && gate;
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign pat_new = {hist_r[nfhm_pkg::PAT_LEN-2:0], fire};

  always_comb begin
    ones = '0;
    for (int j = 0; j < nfhm_pkg::PAT_LEN; j++) begin
      ones = ones + nfhm_pkg::ONES_W'(pat_new[j]);
    end
  end

  // The history rotates by one chunk per scanned chunk, so the comparators
  // always look at the low bits; a full scan brings it back to its place.
  always_comb begin
    hist_nxt = hist_r;
    cnt_nxt  = cnt_r;
    if (cmd.load_tick) begin
      hist_nxt = {hist_r[nfhm_pkg::HIST_LEN-2:0], fire};
      cnt_nxt  = (input_sum != '0) ? '0 : cnt_inc;
    end else if (cmd.load_chunk) begin
      hist_nxt = {hist_r[nfhm_pkg::CHUNK_BITS-1:0],
                  hist_r[nfhm_pkg::HIST_LEN-1:nfhm_pkg::CHUNK_BITS]};
    end
  end

  assign chunk_base = nfhm_pkg::OFF_W'(cmd.chunk) << nfhm_pkg::CHUNK_SH;

  always_comb begin
    logic [nfhm_pkg::OFF_W-1:0] off;
    for (int b = 0; b < nfhm_pkg::CHUNK_BITS; b++) begin
      off = chunk_base | nfhm_pkg::OFF_W'(b);
      match[b] = scan_r
              && (off >= nfhm_pkg::OFF_W'(nfhm_pkg::PAT_LEN))
              && (off < nfhm_pkg::OFF_W'(nfhm_pkg::HIST_LEN - nfhm_pkg::PAT_LEN))
              && (hist_r[b +: nfhm_pkg::PAT_LEN] == pat_r);
    end
  end

  assign stat.out_free = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      hist_r <= hist_nxt;
      cnt_r  <= cnt_nxt;
      if (cmd.load_chunk) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tick) begin
      pat_r   <= pat_new;
      scan_r  <= ones >= nfhm_pkg::ONES_W'(nfhm_pkg::MIN_ONES);
      fired_r <= fire;
      value_r <= fire ? input_sum : '0;
      steps_r <= fire ? cnt_inc : '0;
    end
    if (cmd.load_chunk) begin
      o_fired_r <= fired_r;
      o_value_r <= value_r;
      o_steps_r <= steps_r;
      o_chunk_r <= cmd.chunk;
      o_bits_r  <= match;
      o_last_r  <= cmd.last;
    end
  end

  assign out_valid             = ov_r;
  assign out_fired             = o_fired_r;
  assign out_fire_value        = o_value_r;
  assign out_steps_since_visit = o_steps_r;
  assign out_chunk_index       = o_chunk_r;
  assign out_match_bits        = o_bits_r;
  assign out_last_in_run       = o_last_r;

endmodule

// ===== rtl/core/neuron_fire_history_match_unit.sv =====
// The first chunk beat is registered in the scan state entered on an accepted tick,
// once the output register is free. Throughput: eight chunk beats per tick, one per
// cycle without back-pressure; the next tick is taken the cycle after the last chunk
// loads; 64 window comparators set the rate, scanning one 64-offset chunk per cycle.
// Reset (synchronous, rst_n low): history and idle counter clear, registers return to
// threshold 1, noise 0, enabled 1; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module neuron_fire_history_match_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  nfhm_in_if.sink                     in_ch,
  nfhm_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nfhm_pkg::ADDR_W-1:0] paddr,
  input  logic [nfhm_pkg::DATA_W-1:0] pwdata,
  output logic [nfhm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  nfhm_pkg::cfg_t     cfg;
  nfhm_pkg::dp_cmd_t  cmd;
  nfhm_pkg::dp_stat_t stat;

  nfhm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nfhm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nfhm_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .cmd                   (cmd),
    .stat                  (stat),
    .input_sum             (in_ch.input_sum),
    .random_draw           (in_ch.random_draw),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_fired             (out_ch.fired),
    .out_fire_value        (out_ch.fire_value),
    .out_steps_since_visit (out_ch.steps_since_visit),
    .out_chunk_index       (out_ch.chunk_index),
    .out_match_bits        (out_ch.match_bits),
    .out_last_in_run       (out_ch.last_in_run)
  );

endmodule
